@@ rtl/i2a_pkg.sv @@
package i2a_pkg;

  localparam int VALUE_BITS = 64;
  localparam int DEC_DIGITS = (VALUE_BITS * 3) / 10 + 1;
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int DIGITS     = DEC_DIGITS;
  localparam int DIG_W      = DIGITS * 4;
  localparam int REM_W      = $clog2(DIGITS + 1);
  localparam int CNT_W      = $clog2(VALUE_BITS);

  typedef enum logic [1:0] {
    MODE_SDEC = 2'd0,
    MODE_UDEC = 2'd1,
    MODE_HEXL = 2'd2,
    MODE_HEXU = 2'd3
  } mode_e;

  localparam logic [6:0] CHAR_ZERO    = 7'h30;
  localparam logic [6:0] CHAR_MINUS   = 7'h2D;
  localparam logic [6:0] CHAR_LOWER_A = 7'h61;
  localparam logic [6:0] CHAR_UPPER_A = 7'h41;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic skip_step;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic is_neg;
    logic is_dec;
    logic top_zero;
    logic rem_one;
    logic out_free;
  } stat_t;

  function automatic logic [6:0] digit_char(logic [3:0] d, logic upper);
    logic [6:0] base;
    base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
    if (d < 4'd10) begin
      return CHAR_ZERO + {3'b000, d};
    end
    return base + {3'b000, d} - 7'd10;
  endfunction

endpackage

@@ rtl/i2a_in_if.sv @@
interface i2a_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [1:0]  mode;

  modport source (output valid, output value, output mode, input ready);
  modport sink   (input valid, input value, input mode, output ready);
endinterface

@@ rtl/i2a_out_if.sv @@
interface i2a_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

@@ rtl/i2a_dpath.sv @@
module i2a_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [63:0]         value_i,
  input  logic [1:0]          mode_i,
  input  i2a_pkg::cmd_t       cmd_i,
  output i2a_pkg::stat_t      stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [6:0]          char_code_o,
  output logic                is_last_o
);
  import i2a_pkg::*;

  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [DIG_W-1:0]      dig_q, dig_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic                  neg_q, neg_d;
  logic                  dec_q, dec_d;
  logic                  upper_q, upper_d;
  logic                  out_valid_q;
  logic [6:0]            char_q, char_d;
  logic                  last_q, last_d;

  logic [VALUE_BITS-1:0] in_val;
  logic                  in_neg;
  logic [DIG_W-1:0]      adj;
  logic [4*HEX_DIGITS-1:0] hex_w;
  logic [3:0]            top_dig;
  logic                  emit;

  assign in_val  = value_i[VALUE_BITS-1:0];
  assign in_neg  = (mode_e'(mode_i) == MODE_SDEC) && in_val[VALUE_BITS-1];
  assign hex_w   = (4*HEX_DIGITS)'(in_val);
  assign top_dig = dig_q[DIG_W-1 -: 4];
  assign emit    = cmd_i.emit_sign | cmd_i.emit_digit;

  // Add-three correction of each BCD digit ahead of the shift.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[4*i +: 4] = (dig_q[4*i +: 4] >= 4'd5) ? dig_q[4*i +: 4] + 4'd3
                                                 : dig_q[4*i +: 4];
    end
  end

  always_comb begin
    bin_d   = bin_q;
    dig_d   = dig_q;
    rem_d   = rem_q;
    neg_d   = neg_q;
    dec_d   = dec_q;
    upper_d = upper_q;
    char_d  = char_q;
    last_d  = last_q;
    if (cmd_i.load) begin
      neg_d   = in_neg;
      bin_d   = in_neg ? (~in_val + 1'b1) : in_val;
      dec_d   = (mode_e'(mode_i) == MODE_SDEC) || (mode_e'(mode_i) == MODE_UDEC);
      upper_d = (mode_e'(mode_i) == MODE_HEXU);
      if (dec_d) begin
        dig_d = '0;
        rem_d = REM_W'(DIGITS);
      end else begin
        // Nibbles sit at the top of the digit register, most significant first.
        dig_d = DIG_W'(hex_w) << (4 * (DIGITS - HEX_DIGITS));
        rem_d = REM_W'(HEX_DIGITS);
      end
    end else if (cmd_i.conv_step) begin
      dig_d = {adj[DIG_W-2:0], bin_q[VALUE_BITS-1]};
      bin_d = bin_q << 1;
    end else if (cmd_i.skip_step) begin
      dig_d = dig_q << 4;
      rem_d = rem_q - 1'b1;
    end else if (cmd_i.emit_digit) begin
      char_d = digit_char(top_dig, upper_q);
      last_d = (rem_q == REM_W'(1));
      dig_d  = dig_q << 4;
      rem_d  = rem_q - 1'b1;
    end else if (cmd_i.emit_sign) begin
      char_d = CHAR_MINUS;
      last_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q   <= bin_d;
    dig_q   <= dig_d;
    rem_q   <= rem_d;
    neg_q   <= neg_d;
    dec_q   <= dec_d;
    upper_q <= upper_d;
    char_q  <= char_d;
    last_q  <= last_d;
  end

  assign stat_o.is_neg   = neg_q;
  assign stat_o.is_dec   = dec_q;
  assign stat_o.top_zero = (top_dig == 4'd0);
  assign stat_o.rem_one  = (rem_q == REM_W'(1));
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign is_last_o   = last_q;

endmodule

@@ rtl/i2a_ctrl.sv @@
module i2a_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  i2a_pkg::stat_t stat_i,
  output i2a_pkg::cmd_t  cmd_o
);
  import i2a_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_SIGN,
    S_EMIT
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_CONV;
        end
      end
      S_CONV: begin
        // Hex digits are ready at load; decimal runs one bit a cycle.
        if (!stat_i.is_dec) begin
          state_d = S_SKIP;
        end else begin
          cmd_o.conv_step = 1'b1;
          cnt_d           = cnt_q + 1'b1;
          if (cnt_q == CNT_W'(VALUE_BITS - 1)) begin
            state_d = S_SKIP;
          end
        end
      end
      S_SKIP: begin
        if (stat_i.top_zero && !stat_i.rem_one) begin
          cmd_o.skip_step = 1'b1;
        end else begin
          state_d = stat_i.is_neg ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        if (stat_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          if (stat_i.rem_one) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

@@ rtl/integer_to_ascii_formatter_core.sv @@
// Channel | Dir | Payload                    | Handshake
// in_i    | in  | value[63:0], mode[1:0]     | valid/ready, request taken when both high
// out_o   | out | char_code[6:0], is_last    | valid/ready, one character per transfer
//
// Decimal: load, a double-dabble shift per input bit, a shift per dropped leading
// zero, an exit from the zero scan, then an optional minus sign and the
// characters. Hex: load, a pass through the conversion state, then the zero scan and the characters.
// Reset clears the controller and the output valid flag only.
// A stalled output holds the emitter; the next request is taken once the
// last character is in the output register.
module integer_to_ascii_formatter_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  i2a_in_if.sink    in_i,
  i2a_out_if.source out_o
);
  import i2a_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  i2a_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  i2a_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (in_i.value),
    .mode_i      (in_i.mode),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .char_code_o (out_o.char_code),
    .is_last_o   (out_o.is_last)
  );

endmodule

@@ tb/integer_to_ascii_formatter_core_tb.sv @@
`timescale 1ns / 1ps

module integer_to_ascii_formatter_core_tb;
  import i2a_pkg::*;

  localparam int          QUIET_LIMIT   = 4000;
  localparam int          SETTLE_CYCLES = 150;
  localparam int          RANDOM_ITEMS  = 320;
  localparam logic [63:0] VALUE_MASK    = {64{1'b1}} >> (64 - VALUE_BITS);

  typedef struct packed {
    logic [6:0] char_code;
    logic       is_last;
  } char_t;

  typedef enum int {
    PACE_FREE,
    PACE_COIN,
    PACE_SPARSE,
    PACE_PERIODIC
  } pace_e;

  logic clk_i;
  logic rst_ni;

  i2a_in_if  num_ch ();
  i2a_out_if txt_ch ();

  integer_to_ascii_formatter_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (num_ch),
    .out_o  (txt_ch)
  );

  char_t pending_chars[$];
  int    char_errors   = 0;
  int    quiet_cycles  = 0;
  int    hold_request  = 0;
  int    burst_left    = 0;
  bit    gaps_on       = 1'b1;

  string lower_table = "0123456789abcdef";
  string upper_table = "0123456789ABCDEF";

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Works out the characters that one request should produce and queues them.
  function automatic void predict_text(input logic [63:0] value, input mode_e mode);
    logic [63:0] magnitude;
    logic [63:0] radix;
    logic        negative;
    int          digit_list[20];
    int          ndigits;
    char_t       c;
    byte         ch;
    magnitude = value & VALUE_MASK;
    negative  = (mode == MODE_SDEC) && magnitude[VALUE_BITS-1];
    if (negative) begin
      magnitude = (~magnitude + 64'd1) & VALUE_MASK;
    end
    radix   = (mode == MODE_HEXL || mode == MODE_HEXU) ? 64'd16 : 64'd10;
    ndigits = 0;
    do begin
      digit_list[ndigits] = int'(magnitude % radix);
      ndigits++;
      magnitude = magnitude / radix;
    end while (magnitude != 64'd0 && ndigits < 20);
    if (negative) begin
      c.char_code = CHAR_MINUS;
      c.is_last   = 1'b0;
      pending_chars.push_back(c);
    end
    for (int i = ndigits - 1; i >= 0; i--) begin
      ch          = (mode == MODE_HEXU) ? upper_table[digit_list[i]]
                                        : lower_table[digit_list[i]];
      c.char_code = ch[6:0];
      c.is_last   = (i == 0);
      pending_chars.push_back(c);
    end
  endfunction

  // Mostly awkward magnitudes: short bit lengths, powers of the radix and
  // their neighbours, small negatives, as well as plain full-width values.
  function automatic logic [63:0] random_number();
    logic [63:0] full;
    logic [63:0] p;
    int          kind;
    full = {$urandom, $urandom};
    kind = $urandom_range(0, 9);
    p    = 64'd1;
    case (kind)
      0, 1, 2, 3: return full;
      4, 5: return full >> $urandom_range(0, 63);
      6: return 64'($urandom_range(0, 20));
      7: begin
        repeat ($urandom_range(0, 19)) p = p * 64'd10;
        return p + 64'($urandom_range(0, 2)) - 64'd1;
      end
      8: begin
        p = p << (4 * $urandom_range(0, 15));
        return p + 64'($urandom_range(0, 2)) - 64'd1;
      end
      default: return 64'd0 - 64'($urandom_range(1, 1000));
    endcase
  endfunction

  task automatic offer_number(input logic [63:0] value, input mode_e mode);
    num_ch.valid <= 1'b1;
    num_ch.value <= value;
    num_ch.mode  <= mode;
    do @(posedge clk_i); while (!num_ch.ready);
    predict_text(value, mode);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      if (gaps_on) begin
        num_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
  endtask

  task automatic test_zero();
    offer_number(64'd0, MODE_SDEC);
    offer_number(64'd0, MODE_UDEC);
    offer_number(64'd0, MODE_HEXL);
    offer_number(64'd0, MODE_HEXU);
  endtask

  task automatic test_full_scale();
    offer_number(VALUE_MASK, MODE_SDEC);
    offer_number(VALUE_MASK, MODE_UDEC);
    offer_number(VALUE_MASK, MODE_HEXL);
    offer_number(VALUE_MASK, MODE_HEXU);
    offer_number(VALUE_MASK >> 1, MODE_SDEC);
  endtask

  task automatic test_most_negative();
    offer_number(64'd1 << (VALUE_BITS - 1), MODE_SDEC);
    offer_number(64'd1 << (VALUE_BITS - 1), MODE_UDEC);
    offer_number(64'd1 << (VALUE_BITS - 1), MODE_HEXU);
  endtask

  task automatic test_digit_boundaries();
    offer_number(64'd9, MODE_UDEC);
    offer_number(64'd10, MODE_UDEC);
    offer_number(64'd9999999999999999999, MODE_UDEC);
    offer_number(64'd10000000000000000000, MODE_UDEC);
    offer_number(64'd1, MODE_SDEC);
    offer_number(64'd0 - 64'd10, MODE_SDEC);
  endtask

  task automatic test_hex_letters();
    offer_number(64'hFEDC_BA98_7654_3210, MODE_HEXL);
    offer_number(64'hFEDC_BA98_7654_3210, MODE_HEXU);
  endtask

  // Bits above the value width must have no effect on the text.
  task automatic test_wide_value();
    offer_number(64'hDEAD_0000_0000_0005, MODE_UDEC);
    offer_number(64'hFFFF_FFFF_FFFF_FF85, MODE_SDEC);
  endtask

  // The sink holds off while requests keep coming, so the block backs up
  // and must stall its input without losing or reordering characters.
  task automatic test_output_stall();
    gaps_on      = 1'b0;
    hold_request = 300;
    repeat (12) offer_number(random_number(), mode_e'(2'($urandom_range(0, 3))));
    gaps_on = 1'b1;
  endtask

  task automatic test_random();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 80 == 0) begin
        gaps_on = (i / 80) % 2 == 0;
      end
      offer_number(random_number(), mode_e'(2'($urandom_range(0, 3))));
    end
    gaps_on = 1'b1;
  endtask

  initial begin : sink_pacing
    pace_e pace;
    int    pace_left;
    int    hold_left;
    int    phase;
    pace      = PACE_FREE;
    pace_left = 0;
    hold_left = 0;
    phase     = 0;
    txt_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (pace_left == 0) begin
        pace      = pace_e'($urandom_range(0, 3));
        pace_left = $urandom_range(30, 200);
      end
      pace_left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        txt_ch.ready <= 1'b0;
      end else begin
        case (pace)
          PACE_FREE:   txt_ch.ready <= 1'b1;
          PACE_COIN:   txt_ch.ready <= 1'($urandom_range(0, 1));
          PACE_SPARSE: txt_ch.ready <= ($urandom_range(0, 3) == 0);
          default:     txt_ch.ready <= (phase % 5 != 2);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : check_chars
    char_t got;
    char_t want;
    quiet_cycles++;
    if (rst_ni && num_ch.valid && num_ch.ready) begin
      quiet_cycles = 0;
    end
    if (rst_ni && txt_ch.valid && txt_ch.ready) begin
      quiet_cycles  = 0;
      got.char_code = txt_ch.char_code;
      got.is_last   = txt_ch.is_last;
      if (pending_chars.size() == 0) begin
        char_errors++;
        if (char_errors <= 10) begin
          $display("unexpected character %02h last %0b", got.char_code, got.is_last);
        end
      end else begin
        want = pending_chars.pop_front();
        if (got.char_code !== want.char_code || got.is_last !== want.is_last) begin
          char_errors++;
          if (char_errors <= 10) begin
            $display("character mismatch: expected %02h last %0b, got %02h last %0b",
                     want.char_code, want.is_last, got.char_code, got.is_last);
          end
        end
      end
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    num_ch.valid = 1'b0;
    num_ch.value = 64'd0;
    num_ch.mode  = MODE_SDEC;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero();
    test_full_scale();
    test_most_negative();
    test_digit_boundaries();
    test_hex_letters();
    test_wide_value();
    test_output_stall();
    test_random();

    num_ch.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (char_errors == 0 && pending_chars.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/i2a_pkg.sv
rtl/i2a_in_if.sv
rtl/i2a_out_if.sv
rtl/i2a_dpath.sv
rtl/i2a_ctrl.sv
rtl/integer_to_ascii_formatter_core.sv
tb/integer_to_ascii_formatter_core_tb.sv
